// File: rtl/ipsaf_pkg.sv
// Package for the IPv4 subnet allow filter: operation and status codes,
// field widths, the cell link type and the prefix mask helper.
// No dependencies.
package ipsaf_pkg;

    localparam int ADDR_W   = 32;
    localparam int PLEN_W   = 6;
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int ECNT_W   = 7;
    localparam int IN_DW    = 40;   // address + prefix_len, byte padded
    localparam int OUT_DW   = 16;   // status + permitted + entry_count, byte padded

    localparam int MAX_SUBNETS_DEF = 64;
    localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(32);

    // operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_PREFIX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;

    // query token handed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              hit;
        logic [ADDR_W-1:0] key;
    } t_link;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic              permitted;
        logic [ECNT_W-1:0] entry_count;
    } t_result;

    // left-aligned mask, len is 1..32
    function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] len);
        prefix_mask = ~({ADDR_W{1'b1}} >> len);
    endfunction

    function automatic logic [ADDR_W-1:0] swap_bytes(input logic [ADDR_W-1:0] v);
        swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

// File: rtl/ipsaf_cell.sv
// One table cell: holds one subnet (address and mask) and passes the query
// token to its neighbor, ORing in its own match. Uses ipsaf_pkg.
module ipsaf_cell #(
    parameter int CNT_W    = 7,
    parameter int CELL_IDX = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ipsaf_pkg::t_link              i_link,
    output ipsaf_pkg::t_link              o_link,
    input  logic [CNT_W-1:0]              i_count,
    input  logic                          i_wr_en,
    input  logic [ipsaf_pkg::ADDR_W-1:0]  i_addr,
    input  logic [ipsaf_pkg::ADDR_W-1:0]  i_mask
);

    logic [ipsaf_pkg::ADDR_W-1:0] r_addr;
    logic [ipsaf_pkg::ADDR_W-1:0] r_mask;
    logic                         r_vld;
    logic                         r_hit;
    logic [ipsaf_pkg::ADDR_W-1:0] r_key;
    logic                         w_sel;
    logic                         w_active;
    logic                         w_match;

    assign w_sel    = (i_count == CNT_W'(CELL_IDX));
    assign w_active = (CNT_W'(CELL_IDX) < i_count);
    assign w_match  = w_active && ((r_addr & r_mask) == (i_link.key & r_mask));

    // entry store, written at the current fill position
    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_sel) begin
            r_addr <= i_addr;
            r_mask <= i_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_link.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= i_link.key;
        r_hit <= i_link.hit | w_match;
    end

    assign o_link.vld = r_vld;
    assign o_link.hit = r_hit;
    assign o_link.key = r_key;

endmodule

// File: rtl/ip_subnet_allow_filter.sv
// Top level of the IPv4 subnet allow filter: stream ports, operation
// decode, fill count, the chain of ipsaf_cell and the result register.
// Uses ipsaf_pkg and ipsaf_cell.

// The filter holds up to MAX_SUBNETS IPv4 subnets, one per cell in a chain.
// Each input item is one operation picked by s_axis_tuser: clear, add a subnet
// (address plus prefix length 1..32) or query an address given in opposite byte
// order. Clear and add finish in the accept cycle; their result item is
// registered for the master side, and a new item can be taken every cycle
// while no query is in flight and no result waits in the skid entry. A query
// is byte-swapped and handed cell to cell, one cell per cycle, each cell ORing
// in a match against its own masked entry; once the token has left the last
// cell its result item is registered, and s_axis_tready stays low until then.
// The result is permitted when the table is empty or any entry matches. On an
// add, a bad prefix length gives status 1 (checked first), a full table status
// 2; neither changes the table. entry_count is the count after the operation,
// modulo 128. A result register plus one skid entry let the block take an
// item while a finished result still waits on m_axis_tready.
module ip_subnet_allow_filter #(
    parameter int MAX_SUBNETS = ipsaf_pkg::MAX_SUBNETS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [31:0] address, [37:32] prefix_len, [39:38] zero
    input  logic [ipsaf_pkg::IN_DW-1:0]   s_axis_tdata,
    // [1:0] operation
    input  logic [ipsaf_pkg::OP_W-1:0]    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [1:0] status, [2] permitted, [9:3] entry_count, [15:10] zero
    output logic [ipsaf_pkg::OUT_DW-1:0]  m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_SUBNETS + 1);
    localparam int EXT_W = (CNT_W > ipsaf_pkg::ECNT_W) ? CNT_W : ipsaf_pkg::ECNT_W;

    // input fields
    logic                             w_acc;
    logic [ipsaf_pkg::OP_W-1:0]       w_op;
    logic [ipsaf_pkg::ADDR_W-1:0]     w_addr;
    logic [ipsaf_pkg::PLEN_W-1:0]     w_plen;

    // table control
    logic [CNT_W-1:0]                 r_count;
    logic [CNT_W-1:0]                 n_count;
    logic                             w_wr;
    logic [ipsaf_pkg::STAT_W-1:0]     w_status;
    logic                             r_busy;

    // cell chain
    ipsaf_pkg::t_link                 w_link [0:MAX_SUBNETS];
    logic [ipsaf_pkg::ADDR_W-1:0]     w_mask;

    // completion and output staging
    logic                             w_done;
    logic                             w_last;
    logic [CNT_W-1:0]                 w_cnt_res;
    logic [EXT_W-1:0]                 w_cnt_ext;
    ipsaf_pkg::t_result               w_res;
    ipsaf_pkg::t_result               r_out;
    ipsaf_pkg::t_result               r_skid;
    logic                             r_ovld;
    logic                             r_svld;
    logic                             w_out_free;

    assign w_op   = s_axis_tuser;
    assign w_addr = s_axis_tdata[ipsaf_pkg::ADDR_W-1:0];
    assign w_plen = s_axis_tdata[ipsaf_pkg::ADDR_W +: ipsaf_pkg::PLEN_W];

    // one item in flight; a parked result also holds off input
    assign s_axis_tready = !r_busy && !r_svld;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    // clear / add decode
    always_comb begin
        n_count  = r_count;
        w_wr     = 1'b0;
        w_status = ipsaf_pkg::ST_OK;
        unique case (w_op)
            ipsaf_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            ipsaf_pkg::OP_ADD: begin
                if (w_plen == '0 || w_plen > ipsaf_pkg::PLEN_MAX) begin
                    w_status = ipsaf_pkg::ST_BAD_PREFIX;
                end else if (r_count == CNT_W'(MAX_SUBNETS)) begin
                    w_status = ipsaf_pkg::ST_FULL;
                end else begin
                    w_wr    = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end
            default: begin
                // query and the unused code leave the table alone
            end
        endcase
    end

    assign w_mask = ipsaf_pkg::prefix_mask(w_plen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_acc) begin
            r_count <= n_count;
        end
    end

    // query token enters cell 0; an empty table is a hit from the start
    assign w_link[0].vld = w_acc && (w_op == ipsaf_pkg::OP_QUERY);
    assign w_link[0].hit = (r_count == '0);
    assign w_link[0].key = ipsaf_pkg::swap_bytes(w_addr);

    for (genvar gi = 0; gi < MAX_SUBNETS; gi++) begin : g_cell
        ipsaf_cell #(
            .CNT_W    (CNT_W),
            .CELL_IDX (gi)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (w_link[gi]),
            .o_link  (w_link[gi+1]),
            .i_count (r_count),
            .i_wr_en (w_acc && w_wr),
            .i_addr  (w_addr),
            .i_mask  (w_mask)
        );
    end

    assign w_last = w_link[MAX_SUBNETS].vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_link[0].vld) begin
            r_busy <= 1'b1;
        end else if (w_last) begin
            r_busy <= 1'b0;
        end
    end

    // result of whatever finishes this cycle
    assign w_done    = (w_acc && (w_op != ipsaf_pkg::OP_QUERY)) || w_last;
    assign w_cnt_res = w_last ? r_count : n_count;
    assign w_cnt_ext = EXT_W'(w_cnt_res);

    always_comb begin
        w_res.status      = w_last ? ipsaf_pkg::ST_OK : w_status;
        w_res.permitted   = w_last && w_link[MAX_SUBNETS].hit;
        w_res.entry_count = w_cnt_ext[ipsaf_pkg::ECNT_W-1:0];
    end

    // output register with one skid entry
    assign w_out_free = !r_ovld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
            r_svld <= 1'b0;
        end else begin
            if (w_out_free) begin
                r_ovld <= r_svld || w_done;
                r_svld <= 1'b0;
            end else if (w_done) begin
                r_svld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free) begin
            r_out <= r_svld ? r_skid : w_res;
        end
        if (!w_out_free && w_done) begin
            r_skid <= w_res;
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = ipsaf_pkg::OUT_DW'({r_out.entry_count, r_out.permitted,
                                               r_out.status});

endmodule

// File: rtl/ipsaf_chk.sv
// Port-level checker for ip_subnet_allow_filter, bound to the top level.
// Uses ipsaf_pkg.
module ipsaf_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [ipsaf_pkg::OP_W-1:0]    s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [ipsaf_pkg::OUT_DW-1:0]  m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // status code 3 is never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ipsaf_pkg::ST_OK ||
                           m_axis_tdata[1:0] == ipsaf_pkg::ST_BAD_PREFIX ||
                           m_axis_tdata[1:0] == ipsaf_pkg::ST_FULL))
        else $error("bad status code");

    // a rejected add never reports permitted
    a_perm_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != ipsaf_pkg::ST_OK) |-> !m_axis_tdata[2])
        else $error("permitted set on rejected item");

    // clear/add into an empty output shows its result next cycle
    a_fast_ops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid &&
        (s_axis_tuser != ipsaf_pkg::OP_QUERY) |=> m_axis_tvalid)
        else $error("non-query result late");

endmodule

bind ip_subnet_allow_filter ipsaf_chk u_ipsaf_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
